// ----- sv/crc_checked_packet_parser_assert.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the crc checked packet parser
// each macro samples on clk and is disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_PACKET_PARSER_ASSERT_SVH
`define CRC_CHECKED_PACKET_PARSER_ASSERT_SVH

// condition holds at every edge out of reset
`define CCPP_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CCPP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define CCPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ccpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpp_pkg
// constants, status codes and the crc-16 byte update of the packet parser
// ----------------------------------------------------------------------------
package ccpp_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8005;

	// body lengths of the two known packet kinds
	localparam int DATA_BODY   = 8;
	localparam int CONFIG_BODY = 25;

	// index width of the body byte store (config body is the largest read)
	localparam int STORE_IDX_W = 5;

	typedef enum logic [2:0] {
		ST_DATA   = 3'd0,
		ST_CONFIG = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_LENGTH = 3'd3,
		ST_CRC    = 3'd4,
		ST_ID     = 3'd5
	} status_t;

	// crc-16, poly 0x8005, msb first, one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/ccpp_if.sv -----
// ----------------------------------------------------------------------------
// ccpp channel interfaces
// byte input, result output and configuration write channels
// ----------------------------------------------------------------------------

// received payload bytes
interface ccpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source(output valid, output payload_byte, output last_byte, input ready);
	modport sink(input valid, input payload_byte, input last_byte, output ready);
endinterface

// one parsed packet result
interface ccpp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  received_length;
	logic [7:0]  node_kind;
	logic [47:0] attribute_bytes;
	logic [47:0] node_name;
	logic [63:0] node_eui;
	logic [7:0]  application_id;
	logic [7:0]  radio_channel;
	logic [39:0] pipe_address;
	logic [7:0]  data_rate;
	logic [7:0]  tx_power;

	modport source(
		output valid, output status, output received_length, output node_kind,
		output attribute_bytes, output node_name, output node_eui,
		output application_id, output radio_channel, output pipe_address,
		output data_rate, output tx_power, input ready
	);
	modport sink(
		input valid, input status, input received_length, input node_kind,
		input attribute_bytes, input node_name, input node_eui,
		input application_id, input radio_channel, input pipe_address,
		input data_rate, input tx_power, output ready
	);
endinterface

// expected message id write
interface ccpp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/crc_checked_packet_parser.sv -----
// ----------------------------------------------------------------------------
// crc_checked_packet_parser
// crc-16 checked radio packet parser with big-endian field unpacking
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on rx, one word per byte, last_byte set on the
// final byte of a packet. The trailing two bytes are the crc, high byte first.
// On the last byte one result word leaves on res with a status and the fields
// of a data or config body; fields that do not belong to the status read 0.
// cfg writes the expected message id; write it only while no packet is open.
// Throughput: one byte per cycle, set by the combinational crc byte update,
// while no last byte waits on an untaken result. A last byte passes the
// input stage, then loads the result register that offers the result word.
// Reset: packet state returns to crc 0xFFFF and count 0, no result is pending
// and the expected id is 0.
// Stall: a pending result is held until taken; bytes other than a last byte
// keep flowing, a last byte waits in the input stage while the previous
// result is still untaken.
// ----------------------------------------------------------------------------
`include "crc_checked_packet_parser_assert.svh"

module crc_checked_packet_parser #(
	parameter int MAX_PAYLOAD = 32
) (
	input logic        clk,
	input logic        arst_n,
	ccpp_cfg_if.sink   cfg,
	ccpp_byte_if.sink  rx,
	ccpp_result_if.source res
);
	import ccpp_pkg::*;

	localparam int CNT_W     = $clog2(MAX_PAYLOAD + 1);
	localparam int OVER_MARK = (MAX_PAYLOAD + 1 > 63) ? 63 : MAX_PAYLOAD + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

	// configuration
	logic [7:0] msg_id_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// packet state
	logic [15:0]      crc_q;
	logic [15:0]      dly_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [7:0]       store_q [CONFIG_BODY];

	// next packet state
	logic             take;
	logic             room;
	logic [15:0]      crc_n;
	logic [15:0]      dly_n;
	logic [CNT_W-1:0] cnt_n;
	logic             ovf_n;
	logic [6:0]       cnt_wide;

	// result computed from the next state
	status_t     status_c;
	logic [5:0]  len_c;
	logic [7:0]  dev_c;
	logic [47:0] attr_c;
	logic [47:0] name_c;
	logic [63:0] eui_c;
	logic [7:0]  app_c;
	logic [7:0]  chan_c;
	logic [39:0] pipe_c;
	logic [7:0]  rate_c;
	logic [7:0]  pwr_c;

	// result register
	logic        res_valid_q;
	status_t     status_q;
	logic [5:0]  len_q;
	logic [7:0]  dev_q;
	logic [47:0] attr_q;
	logic [47:0] name_q;
	logic [63:0] eui_q;
	logic [7:0]  app_q;
	logic [7:0]  chan_q;
	logic [39:0] pipe_q;
	logic [7:0]  rate_q;
	logic [7:0]  pwr_q;

	// configuration write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_id_q <= '0;
		end else if (cfg.valid) begin
			msg_id_q <= cfg.data;
		end
	end

	// input stage advances unless a last byte meets an untaken result
	assign take     = valid_s1 && (!last_s1 || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.payload_byte;
			last_s1 <= rx.last_byte;
		end
	end

	// crc runs two bytes behind, the held-back pair is the received crc
	always_comb begin
		room  = cnt_q < CNT_MAX;
		crc_n = crc_q;
		dly_n = dly_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q | !room;
		if (room) begin
			if (cnt_q >= CNT_W'(2)) begin
				crc_n = crc_feed(crc_q, dly_q[15:8]);
			end
			dly_n = {dly_q[7:0], byte_s1};
			cnt_n = cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			dly_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (last_s1) begin
				crc_q <= CRC_INIT;
				dly_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				crc_q <= crc_n;
				dly_q <= dly_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// body byte store, only the places a config body reads are kept
	always_ff @(posedge clk) begin
		if (take && room && (cnt_q < CNT_W'(CONFIG_BODY))) begin
			store_q[cnt_q[STORE_IDX_W-1:0]] <= byte_s1;
		end
	end

	// status checks and field unpacking
	always_comb begin
		cnt_wide = 7'(cnt_n);
		if (ovf_n) begin
			len_c = 6'(OVER_MARK);
		end else if (cnt_wide > 7'd63) begin
			len_c = 6'd63;
		end else begin
			len_c = cnt_wide[5:0];
		end

		dev_c  = '0;
		attr_c = '0;
		name_c = '0;
		eui_c  = '0;
		app_c  = '0;
		chan_c = '0;
		pipe_c = '0;
		rate_c = '0;
		pwr_c  = '0;

		if (ovf_n || (cnt_n < CNT_W'(2))) begin
			status_c = ST_LENGTH;
		end else if (crc_n != dly_n) begin
			status_c = ST_CRC;
		end else if (cnt_n == CNT_W'(2)) begin
			status_c = ST_EMPTY;
		end else if (store_q[0] != msg_id_q) begin
			status_c = ST_ID;
		end else if (cnt_n == CNT_W'(DATA_BODY + 2)) begin
			status_c = ST_DATA;
			dev_c    = store_q[1];
			attr_c   = {store_q[2], store_q[3], store_q[4], store_q[5], store_q[6],
				store_q[7]};
		end else if (cnt_n == CNT_W'(CONFIG_BODY + 2)) begin
			status_c = ST_CONFIG;
			name_c   = {store_q[1], store_q[2], store_q[3], store_q[4], store_q[5],
				store_q[6]};
			dev_c    = store_q[7];
			eui_c    = {store_q[8], store_q[9], store_q[10], store_q[11], store_q[12],
				store_q[13], store_q[14], store_q[15]};
			app_c    = store_q[16];
			chan_c   = store_q[17];
			pipe_c   = {store_q[18], store_q[19], store_q[20], store_q[21], store_q[22]};
			rate_c   = store_q[23];
			pwr_c    = store_q[24];
		end else begin
			status_c = ST_LENGTH;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			status_q <= status_c;
			len_q    <= len_c;
			dev_q    <= dev_c;
			attr_q   <= attr_c;
			name_q   <= name_c;
			eui_q    <= eui_c;
			app_q    <= app_c;
			chan_q   <= chan_c;
			pipe_q   <= pipe_c;
			rate_q   <= rate_c;
			pwr_q    <= pwr_c;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = status_q;
	assign res.received_length = len_q;
	assign res.node_kind       = dev_q;
	assign res.attribute_bytes = attr_q;
	assign res.node_name       = name_q;
	assign res.node_eui        = eui_q;
	assign res.application_id  = app_q;
	assign res.radio_channel   = chan_q;
	assign res.pipe_address    = pipe_q;
	assign res.data_rate       = rate_q;
	assign res.tx_power        = pwr_q;

	// checks
	`CCPP_ASSERT_HOLDS(a_cnt_bound, cnt_q <= CNT_MAX, "byte count above limit")
	`CCPP_ASSERT_IMPLIES(a_ovf_full, ovf_q, cnt_q == CNT_MAX, "overlength without full count")
	`CCPP_ASSERT_NEXT(a_clear_after_last, take && last_s1,
		cnt_q == '0 && crc_q == CRC_INIT && !ovf_q && res_valid_q, "packet state not cleared")
	`CCPP_ASSERT_IMPLIES(a_data_len, res_valid_q && status_q == ST_DATA,
		len_q == 6'(DATA_BODY + 2), "data result with wrong length")
	`CCPP_ASSERT_IMPLIES(a_config_len, res_valid_q && status_q == ST_CONFIG,
		len_q == 6'(CONFIG_BODY + 2), "config result with wrong length")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: crc checked packet parser testbench
// Builds radio frames with good, broken and missing crc tails, streams them
// into the parser under random source and sink gaps, and checks every result
// word field by field against a cycle-free software parser kept in step with
// each accepted byte. The expected message id is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import ccpp_pkg::*;

	localparam int MAX_LEN     = 32;
	localparam int OVER_LEN    = (MAX_LEN + 1 > 63) ? 63 : MAX_LEN + 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BYTES = 120;
	localparam int SINK_HOLD   = 300;

	typedef logic [7:0] octet_q_t[$];

	typedef struct packed {
		logic [7:0] b;
		logic       l;
	} rx_word_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  received_length;
		logic [7:0]  node_kind;
		logic [47:0] attribute_bytes;
		logic [47:0] node_name;
		logic [63:0] node_eui;
		logic [7:0]  application_id;
		logic [7:0]  radio_channel;
		logic [39:0] pipe_address;
		logic [7:0]  data_rate;
		logic [7:0]  tx_power;
	} parse_result_t;

	typedef enum {TAIL_GOOD, TAIL_BAD, TAIL_RAW} tail_t;
	typedef enum {PH_DIRECTED, PH_SLOW_SINK, PH_SLOW_SOURCE, PH_STEADY} phase_t;

	logic clk;
	logic arst_n;

	ccpp_cfg_if    cfg();
	ccpp_byte_if   rx();
	ccpp_result_if res();

	crc_checked_packet_parser #(.MAX_PAYLOAD(MAX_LEN)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.res    (res)
	);

	// parser shadow state
	logic [7:0]  msg_id = 8'h00;
	logic [15:0] crc_acc = 16'hFFFF;
	logic [15:0] tail_bytes = 16'h0000;
	int          byte_cnt = 0;
	bit          overlong = 1'b0;
	logic [7:0]  pkt_store [32];

	rx_word_t      byte_q[$];
	parse_result_t result_q[$];
	int            queued_cnt = 0;
	int            accepted_cnt = 0;
	int            fail_count = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 21;
	int            recv_idle_pct = 70;
	phase_t        phase = PH_DIRECTED;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// crc-16 0x8005, one bit at a time, msb first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ 16'h8005;
			end
		end
		return crc;
	endfunction

	// big-endian pack of stored body bytes
	function automatic logic [63:0] be_field(input int first, input int count);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < count; k++) begin
			v = {v[55:0], pkt_store[first + k]};
		end
		return v;
	endfunction

	// advance the shadow parser by one byte; returns 1 when a result is due
	function automatic bit parse_byte(input logic [7:0] b, input logic l,
			output parse_result_t r);
		int body;
		r = '0;
		if (byte_cnt < MAX_LEN) begin
			if (byte_cnt >= 2) begin
				crc_acc = crc16_step(crc_acc, tail_bytes[15:8]);
			end
			tail_bytes = {tail_bytes[7:0], b};
			if (byte_cnt < 32) begin
				pkt_store[byte_cnt] = b;
			end
			byte_cnt++;
		end else begin
			overlong = 1'b1;
		end
		if (!l) begin
			return 1'b0;
		end
		r.received_length = 6'(overlong ? OVER_LEN : byte_cnt);
		body = byte_cnt - 2;
		if (overlong || byte_cnt < 2) begin
			r.status = ST_LENGTH;
		end else if (crc_acc != tail_bytes) begin
			r.status = ST_CRC;
		end else if (body == 0) begin
			r.status = ST_EMPTY;
		end else if (pkt_store[0] != msg_id) begin
			r.status = ST_ID;
		end else if (body == DATA_BODY) begin
			r.status = ST_DATA;
			r.node_kind = pkt_store[1];
			r.attribute_bytes = 48'(be_field(2, 6));
		end else if (body == CONFIG_BODY) begin
			r.status = ST_CONFIG;
			r.node_name = 48'(be_field(1, 6));
			r.node_kind = pkt_store[7];
			r.node_eui = be_field(8, 8);
			r.application_id = pkt_store[16];
			r.radio_channel = pkt_store[17];
			r.pipe_address = 40'(be_field(18, 5));
			r.data_rate = pkt_store[23];
			r.tx_power = pkt_store[24];
		end else begin
			r.status = ST_LENGTH;
		end
		crc_acc = 16'hFFFF;
		tail_bytes = '0;
		byte_cnt = 0;
		overlong = 1'b0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// body of len bytes, first byte the message id or a different one
	function automatic octet_q_t random_body(input int len, input bit id_match);
		octet_q_t q;
		for (int k = 0; k < len; k++) begin
			q.push_back(8'($urandom));
		end
		if (len > 0) begin
			q[0] = id_match ? msg_id : msg_id ^ 8'($urandom_range(1, 255));
		end
		return q;
	endfunction

	// append crc tail as asked and queue the frame, last mark on its final word
	task automatic queue_frame(input octet_q_t body, input tail_t tail);
		logic [15:0] crc;
		octet_q_t    all;
		crc = 16'hFFFF;
		all = body;
		foreach (body[k]) begin
			crc = crc16_step(crc, body[k]);
		end
		if (tail == TAIL_BAD) begin
			crc = crc ^ (16'h1 << $urandom_range(15));
		end
		if (tail != TAIL_RAW) begin
			all.push_back(crc[15:8]);
			all.push_back(crc[7:0]);
		end
		foreach (all[k]) begin
			byte_q.push_back(rx_word_t'{all[k], k == all.size() - 1});
		end
		queued_cnt += all.size();
	endtask

	// one random frame, mostly well-formed
	task automatic queue_random_frame();
		int pick;
		int len;
		pick = $urandom_range(99);
		len = $urandom_range(1) ? DATA_BODY : CONFIG_BODY;
		if (pick < 35) begin
			queue_frame(random_body(DATA_BODY, 1'b1), TAIL_GOOD);
		end else if (pick < 60) begin
			queue_frame(random_body(CONFIG_BODY, 1'b1), TAIL_GOOD);
		end else if (pick < 68) begin
			queue_frame(random_body(len, 1'b0), TAIL_GOOD);
		end else if (pick < 75) begin
			queue_frame(random_body(len, 1'b1), TAIL_BAD);
		end else if (pick < 83) begin
			queue_frame(random_body($urandom_range(0, MAX_LEN - 2), 1'b1), TAIL_GOOD);
		end else if (pick < 91) begin
			queue_frame(random_body($urandom_range(1, 12), $urandom_range(1)), TAIL_RAW);
		end else if (pick < 96) begin
			queue_frame(random_body($urandom_range(MAX_LEN + 1, MAX_LEN + 8), 1'b1),
				TAIL_RAW);
		end else begin
			queue_frame(random_body($urandom_range(MAX_LEN - 1, MAX_LEN + 4), 1'b1),
				TAIL_GOOD);
		end
	endtask

	// wait until every queued word is taken and every result word checked
	task automatic drain();
		while (accepted_cnt != queued_cnt || result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_msg_id(input logic [7:0] id);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= id;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		msg_id = id;
	endtask

	// byte driver, shadow parser advanced on every accepted word
	always @(posedge clk or negedge arst_n) begin : byte_driver
		rx_word_t      w;
		parse_result_t pred;
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.payload_byte <= '0;
			rx.last_byte <= 1'b0;
		end else begin
			if (rx.valid && rx.ready) begin
				accepted_cnt++;
				if (parse_byte(rx.payload_byte, rx.last_byte, pred)) begin
					result_q.push_back(pred);
				end
			end
			if (!rx.valid || rx.ready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					w = byte_q.pop_front();
					rx.valid <= 1'b1;
					rx.payload_byte <= w.b;
					rx.last_byte <= w.l;
				end else begin
					rx.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and sink backpressure
	always @(posedge clk or negedge arst_n) begin : result_monitor
		parse_result_t want;
		phase_t        seen_phase;
		int            hold_left;
		if (!arst_n) begin
			res.ready <= 1'b0;
			seen_phase = PH_DIRECTED;
			hold_left = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (result_q.size() == 0) begin
					$error("result word with no packet pending");
					fail_count++;
				end else begin
					want = result_q.pop_front();
					check_field("status", 64'(want.status), 64'(res.status));
					check_field("received_length", 64'(want.received_length),
						64'(res.received_length));
					check_field("node_kind", 64'(want.node_kind), 64'(res.node_kind));
					check_field("attribute_bytes", 64'(want.attribute_bytes),
						64'(res.attribute_bytes));
					check_field("node_name", 64'(want.node_name), 64'(res.node_name));
					check_field("node_eui", want.node_eui, res.node_eui);
					check_field("application_id", 64'(want.application_id),
						64'(res.application_id));
					check_field("radio_channel", 64'(want.radio_channel),
						64'(res.radio_channel));
					check_field("pipe_address", 64'(want.pipe_address),
						64'(res.pipe_address));
					check_field("data_rate", 64'(want.data_rate), 64'(res.data_rate));
					check_field("tx_power", 64'(want.tx_power), 64'(res.tx_power));
				end
			end
			// long sink stall at the start of the steady phase
			if (phase != seen_phase) begin
				seen_phase = phase;
				if (phase == PH_STEADY) begin
					hold_left = SINK_HOLD;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin : stimulus
		octet_q_t body;
		int       start_cnt;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames, id 0
		set_msg_id(8'h00);
		queue_frame('{8'hFF}, TAIL_RAW);
		queue_frame('{}, TAIL_GOOD);
		queue_frame('{8'h00, 8'h00}, TAIL_RAW);
		body = random_body(DATA_BODY, 1'b1);
		foreach (body[k]) if (k > 0) body[k] = 8'hFF;
		queue_frame(body, TAIL_GOOD);
		body = random_body(DATA_BODY, 1'b1);
		foreach (body[k]) if (k > 0) body[k] = 8'h00;
		queue_frame(body, TAIL_GOOD);
		body = random_body(CONFIG_BODY, 1'b1);
		foreach (body[k]) if (k > 0) body[k] = 8'hFF;
		queue_frame(body, TAIL_GOOD);
		queue_frame(random_body(CONFIG_BODY, 1'b1), TAIL_GOOD);
		queue_frame(random_body(CONFIG_BODY, 1'b0), TAIL_GOOD);
		queue_frame(random_body(DATA_BODY, 1'b1), TAIL_BAD);
		queue_frame(random_body(5, 1'b1), TAIL_GOOD);
		queue_frame(random_body(MAX_LEN - 2, 1'b1), TAIL_GOOD);
		queue_frame(random_body(MAX_LEN + 1, 1'b1), TAIL_RAW);
		queue_frame(random_body(MAX_LEN + 6, 1'b1), TAIL_GOOD);
		drain();

		// random frames, slow sink
		set_msg_id(8'hFF);
		phase <= PH_SLOW_SINK;
		start_cnt = queued_cnt;
		while (queued_cnt - start_cnt < PHASE_BYTES) queue_random_frame();
		drain();

		// random frames, slow source
		set_msg_id(8'($urandom));
		send_idle_pct <= 70;
		recv_idle_pct <= 21;
		phase <= PH_SLOW_SOURCE;
		start_cnt = queued_cnt;
		while (queued_cnt - start_cnt < PHASE_BYTES) queue_random_frame();
		drain();

		// random frames, no gaps, long sink stall at the start
		set_msg_id(8'($urandom));
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		phase <= PH_STEADY;
		start_cnt = queued_cnt;
		while (queued_cnt - start_cnt < PHASE_BYTES) queue_random_frame();
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- crc_checked_packet_parser.f -----
+incdir+sv
sv/ccpp_pkg.sv
sv/ccpp_if.sv
sv/crc_checked_packet_parser.sv
tb/sv/tb_top.sv
